// ===== hdl/spl_pkg.sv =====
// Shared types, widths and codes for the sorted priority list.
package spl_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int COUNT_W    = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int FIELD_W    = 10;
    localparam int FILL_W     = 7;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int ENTRY_W    = 3 * FIELD_W;
    localparam int S_DATA_W   = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((ENTRY_W + FILL_W + 7) / 8) * 8;

    // The identifier sits in the lowest bits.
    typedef struct packed {
        logic [FIELD_W-1:0] dc;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] id;
    } entry_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_POP    = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_POP,
        OP_CLEAR
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        op_t     op;
        logic    load;
        status_t status;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic empty;
    } stat_t;

endpackage

// ===== hdl/spl_ctrl.sv =====
// Controller: handshake state machine and request decoding for the sorted priority list.
module spl_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [spl_pkg::REQ_W-1:0]    req,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  spl_pkg::stat_t               stat,
    output spl_pkg::cmd_t                cmd
);
    import spl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE) || m_tready;
        m_tvalid   = (state_reg == ST_HOLD);
        accept     = s_tvalid && s_tready;
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.load   = accept;
        cmd.status = STATUS_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (m_tready && !accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (accept)
        begin
            unique case (req_t'(req))
                REQ_INSERT:
                begin
                    if (stat.full)
                    begin
                        cmd.status = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.op = OP_INSERT;
                    end
                end
                REQ_POP:
                begin
                    if (stat.empty)
                    begin
                        cmd.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        cmd.op = OP_POP;
                    end
                end
                REQ_CLEAR:
                begin
                    cmd.op = OP_CLEAR;
                end
                default:
                begin
                    cmd.op = OP_NONE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_INSERT) |-> !stat.full)
        else $error("insert issued into a full list");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_POP) |-> !stat.empty)
        else $error("pop issued on an empty list");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted beat produced no result");
`endif

endmodule

// ===== hdl/spl_datapath.sv =====
// Datapath: shifting cell array of sorted entries, fill count and result register.
module spl_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spl_pkg::cmd_t                 cmd,
    input  spl_pkg::entry_t               new_entry,
    output spl_pkg::stat_t                stat,
    output spl_pkg::entry_t               res_entry,
    output logic [spl_pkg::STATUS_W-1:0]  res_status,
    output logic [spl_pkg::FILL_W-1:0]    res_fill
);
    import spl_pkg::*;

    entry_t               cell_reg   [LIST_DEPTH];
    entry_t               cell_next  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] ahead;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    entry_t               res_entry_reg;
    status_t              res_status_reg;
    logic [FILL_W-1:0]    res_fill_reg;

    assign stat.full  = (count_reg == COUNT_W'(LIST_DEPTH));
    assign stat.empty = (count_reg == '0);

    // A cell marked ahead keeps its entry on insert. The head also stays ahead
    // of an equal key, so an equal head is never displaced.
    genvar i;
    generate
        for (i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            logic valid;
            assign valid = (COUNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign ahead[i] = valid && (cell_reg[i].key >= new_entry.key);
            end
            else
            begin : g_body
                assign ahead[i] = valid && (cell_reg[i].key > new_entry.key);
            end

            always_comb
            begin
                cell_next[i] = cell_reg[i];
                case (cmd.op)
                    OP_INSERT:
                    begin
                        if (!ahead[i])
                        begin
                            if (i == 0)
                            begin
                                cell_next[i] = new_entry;
                            end
                            else if (ahead[(i == 0) ? 0 : i - 1])
                            begin
                                cell_next[i] = new_entry;
                            end
                            else
                            begin
                                cell_next[i] = cell_reg[(i == 0) ? 0 : i - 1];
                            end
                        end
                    end
                    OP_POP:
                    begin
                        if (i < LIST_DEPTH - 1)
                        begin
                            cell_next[i] = cell_reg[(i < LIST_DEPTH - 1) ? i + 1 : i];
                        end
                    end
                    default:
                    begin
                        cell_next[i] = cell_reg[i];
                    end
                endcase
            end

            always_ff @(posedge clk)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    endgenerate

    always_comb
    begin
        case (cmd.op)
            OP_INSERT: count_next = count_reg + COUNT_W'(1);
            OP_POP:    count_next = count_reg - COUNT_W'(1);
            OP_CLEAR:  count_next = '0;
            default:   count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_entry_reg  <= (cmd.op == OP_POP) ? cell_reg[0] : '0;
            res_status_reg <= cmd.status;
            res_fill_reg   <= FILL_W'(count_next);
        end
    end

    assign res_entry  = res_entry_reg;
    assign res_status = res_status_reg;
    assign res_fill   = res_fill_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(LIST_DEPTH))
        else $error("fill count beyond list depth");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= COUNT_W'(2)) |-> (cell_reg[0].key >= cell_reg[1].key))
        else $error("head entry out of order");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_POP) |=> (count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("pop did not lower the fill count");
`endif

endmodule

// ===== hdl/sorted_priority_list_top.sv =====
// Top level of the sorted priority list: stream ports, controller and datapath.
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tuser: req_type; tdata: entry_id, sort_key, dc_count
//  m_*      | out       | tuser: status; tdata: out_id, out_key, out_dc_count,
//           |           |        fill_level
//
// The whole cell array compares its keys against the incoming key in parallel
// and shifts in the same edge, so a new beat can be accepted every cycle
// unless a held result stalls the slave side. The result beat is registered
// and shows on the master side in the cycle after the request is accepted.
// Reset (rst_n low, asynchronous) empties the list and drops any held result.
// A held result does not block the slave side when m_tready is high in the
// same cycle; with m_tready low the slave side stalls until the result leaves.
module sorted_priority_list_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0 up: entry_id, sort_key, dc_count, zero fill.
    input  logic [spl_pkg::S_DATA_W-1:0]     s_tdata,
    // Fields from bit 0 up: req_type.
    input  logic [spl_pkg::REQ_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0 up: out_id, out_key, out_dc_count, fill_level, zero fill.
    output logic [spl_pkg::M_DATA_W-1:0]     m_tdata,
    // Fields from bit 0 up: status.
    output logic [spl_pkg::STATUS_W-1:0]     m_tuser
);
    import spl_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    entry_t             new_entry;
    entry_t             res_entry;
    logic [STATUS_W-1:0] res_status;
    logic [FILL_W-1:0]  res_fill;

    // The packed entry layout matches the beat layout, id in the lowest bits.
    assign new_entry = entry_t'(s_tdata[ENTRY_W-1:0]);

    spl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req      (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spl_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .new_entry  (new_entry),
        .stat       (stat),
        .res_entry  (res_entry),
        .res_status (res_status),
        .res_fill   (res_fill)
    );

    // Result beat: popped entry (zero unless a pop succeeded) and fill level.
    assign m_tdata = {{(M_DATA_W - ENTRY_W - FILL_W){1'b0}}, res_fill, res_entry};
    assign m_tuser = res_status;

endmodule
